/* hw/rtl/differential_drive_mixer_slew_core_macros.svh */
// assertion macros shared by the mixer modules
// each expects i_clk and i_rst_n in the enclosing module
`ifndef DIFFERENTIAL_DRIVE_MIXER_SLEW_CORE_MACROS_SVH
`define DIFFERENTIAL_DRIVE_MIXER_SLEW_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define DDMS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ddms same-cycle check failed");

// next-cycle implication
`define DDMS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ddms next-cycle check failed");

`else

`define DDMS_ASSERT_IMP(label, ante, cons)
`define DDMS_ASSERT_NXT(label, ante, cons)

`endif

`endif

/* hw/rtl/ddms_pkg.sv */
`default_nettype none
package ddms_pkg;

    // field widths
    localparam int unsigned CMD_W  = 9;
    localparam int unsigned PWR_W  = 11;
    localparam int unsigned CFG_W  = 10;
    localparam int unsigned WIDE_W = 12;
    localparam int unsigned PROD_W = 2 * CFG_W;

    // divider: one quotient bit per step
    localparam int unsigned DIV_STEPS = CFG_W;
    localparam int unsigned CNT_W     = 4;

    // configuration registers
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MOTOR_MAX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP  = 1'b1;
    localparam logic [CFG_W-1:0] MOTOR_MAX_RST = 10'd255;
    localparam logic [CFG_W-1:0] MAX_STEP_RST  = 10'd10;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic mix_en;
        logic mul_en;
        logic div_en;
        logic tgt_en;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_last;
    } t_dp_sts;

    // symmetric clamp to +/- lim
    function automatic logic signed [WIDE_W-1:0] f_clamp(
        input logic signed [WIDE_W-1:0] v,
        input logic [CFG_W-1:0] lim
    );
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = signed'({2'b00, lim});
        lo = -hi;
        if (v > hi) begin
            f_clamp = hi;
        end else if (v < lo) begin
            f_clamp = lo;
        end else begin
            f_clamp = v;
        end
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/ddms_cmd_if.sv */
`default_nettype none
interface ddms_cmd_if import ddms_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [CMD_W-1:0] speed;
    logic signed [CMD_W-1:0] turn;

    modport source (output valid, output speed, output turn, input ready);
    modport sink (input valid, input speed, input turn, output ready);
endinterface
`default_nettype wire

/* hw/rtl/ddms_res_if.sv */
`default_nettype none
interface ddms_res_if import ddms_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [PWR_W-1:0] target_left;
    logic signed [PWR_W-1:0] target_right;
    logic signed [PWR_W-1:0] left_power;
    logic signed [PWR_W-1:0] right_power;
    logic                    left_reverse;
    logic                    right_reverse;
    logic [CFG_W-1:0]        left_duty;
    logic [CFG_W-1:0]        right_duty;

    modport source (
        output valid, input ready,
        output target_left, output target_right,
        output left_power, output right_power,
        output left_reverse, output right_reverse,
        output left_duty, output right_duty
    );
    modport sink (
        input valid, output ready,
        input target_left, input target_right,
        input left_power, input right_power,
        input left_reverse, input right_reverse,
        input left_duty, input right_duty
    );
endinterface
`default_nettype wire

/* hw/rtl/ddms_div_lane.sv */
`default_nettype none
module ddms_div_lane import ddms_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_load,
    input  wire logic              i_step,
    input  wire logic [PROD_W-1:0] i_num,
    input  wire logic [CFG_W-1:0]  i_den,
    output logic [CFG_W-1:0]       o_quot
);

    logic [CFG_W-1:0] r_rem;
    logic [CFG_W-1:0] r_dq;
    logic [CFG_W:0]   trial;
    logic [CFG_W:0]   diff;
    logic             ge;

    // restoring step: shift in next dividend bit, subtract when it fits
    assign trial = {r_rem, r_dq[CFG_W-1]};
    assign diff  = trial - {1'b0, i_den};
    assign ge    = (trial >= {1'b0, i_den});

    // upper half starts as partial remainder, lower half shifts out
    // dividend bits and shifts in quotient bits
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= i_num[PROD_W-1:CFG_W];
            r_dq  <= i_num[CFG_W-1:0];
        end else if (i_step) begin
            r_rem <= ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
            r_dq  <= {r_dq[CFG_W-2:0], ge};
        end
    end

    assign o_quot = r_dq;

endmodule
`default_nettype wire

/* hw/rtl/ddms_datapath.sv */
`default_nettype none
`include "differential_drive_mixer_slew_core_macros.svh"
module ddms_datapath import ddms_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_dp_cmd                 i_cmd,
    output t_dp_sts                      o_sts,
    input  wire logic signed [CMD_W-1:0] i_speed,
    input  wire logic signed [CMD_W-1:0] i_turn,
    input  wire logic [CFG_W-1:0]        i_motor_max,
    input  wire logic [CFG_W-1:0]        i_max_step,
    output logic signed [PWR_W-1:0]      o_target_left,
    output logic signed [PWR_W-1:0]      o_target_right,
    output logic signed [PWR_W-1:0]      o_left_power,
    output logic signed [PWR_W-1:0]      o_right_power,
    output logic                         o_left_reverse,
    output logic                         o_right_reverse,
    output logic [CFG_W-1:0]             o_left_duty,
    output logic [CFG_W-1:0]             o_right_duty
);

    logic signed [PWR_W-1:0]  r_rl;
    logic signed [PWR_W-1:0]  r_rr;
    logic [CFG_W-1:0]         r_abs_l;
    logic [CFG_W-1:0]         r_abs_r;
    logic [CFG_W-1:0]         r_mag;
    logic                     r_scale;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [PWR_W-1:0]  r_tl;
    logic signed [PWR_W-1:0]  r_tr;
    logic signed [PWR_W-1:0]  r_out_tl;
    logic signed [PWR_W-1:0]  r_out_tr;
    logic signed [PWR_W-1:0]  r_app_l;
    logic signed [PWR_W-1:0]  r_app_r;
    logic                     r_rev_l;
    logic                     r_rev_r;
    logic [CFG_W-1:0]         r_duty_l;
    logic [CFG_W-1:0]         r_duty_r;

    logic signed [PWR_W-1:0]  speed_x;
    logic signed [PWR_W-1:0]  turn_x;
    logic signed [PWR_W-1:0]  neg_rl;
    logic signed [PWR_W-1:0]  neg_rr;
    logic [CFG_W-1:0]         abs_l;
    logic [CFG_W-1:0]         abs_r;
    logic [CFG_W-1:0]         mag;
    logic [PROD_W-1:0]        prod_l;
    logic [PROD_W-1:0]        prod_r;
    logic [CFG_W-1:0]         q_l;
    logic [CFG_W-1:0]         q_r;
    logic signed [PWR_W-1:0]  qs_l;
    logic signed [PWR_W-1:0]  qs_r;
    logic signed [PWR_W-1:0]  pick_l;
    logic signed [PWR_W-1:0]  pick_r;
    logic signed [WIDE_W-1:0] tcl_l;
    logic signed [WIDE_W-1:0] tcl_r;
    logic signed [WIDE_W-1:0] cur_l;
    logic signed [WIDE_W-1:0] cur_r;
    logic signed [WIDE_W-1:0] dlt_l;
    logic signed [WIDE_W-1:0] dlt_r;
    logic signed [WIDE_W-1:0] new_l;
    logic signed [WIDE_W-1:0] new_r;
    logic signed [PWR_W-1:0]  nneg_l;
    logic signed [PWR_W-1:0]  nneg_r;

    // mix: sign-extend and form both raw sides
    assign speed_x = PWR_W'(i_speed);
    assign turn_x  = PWR_W'(i_turn);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_rl <= speed_x + turn_x;
            r_rr <= speed_x - turn_x;
        end
    end

    // magnitudes and scale decision
    assign neg_rl = -r_rl;
    assign neg_rr = -r_rr;
    assign abs_l  = r_rl[PWR_W-1] ? neg_rl[CFG_W-1:0] : r_rl[CFG_W-1:0];
    assign abs_r  = r_rr[PWR_W-1] ? neg_rr[CFG_W-1:0] : r_rr[CFG_W-1:0];
    assign mag    = (abs_l > abs_r) ? abs_l : abs_r;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mix_en) begin
            r_abs_l <= abs_l;
            r_abs_r <= abs_r;
            r_mag   <= mag;
            r_scale <= (mag > i_motor_max);
        end
    end

    // products feed the divider registers directly
    assign prod_l = r_abs_l * i_motor_max;
    assign prod_r = r_abs_r * i_motor_max;

    ddms_div_lane u_div_l (
        .i_clk  (i_clk),
        .i_load (i_cmd.mul_en),
        .i_step (i_cmd.div_en),
        .i_num  (prod_l),
        .i_den  (r_mag),
        .o_quot (q_l)
    );

    ddms_div_lane u_div_r (
        .i_clk  (i_clk),
        .i_load (i_cmd.mul_en),
        .i_step (i_cmd.div_en),
        .i_num  (prod_r),
        .i_den  (r_mag),
        .o_quot (q_r)
    );

    // divide step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.mul_en) begin
            r_cnt <= CNT_W'(DIV_STEPS - 1);
        end else if (i_cmd.div_en && (r_cnt != '0)) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_sts.div_last = (r_cnt == '0);

    // targets: signed quotient when scaling, then clamp
    assign qs_l   = signed'({1'b0, q_l});
    assign qs_r   = signed'({1'b0, q_r});
    assign pick_l = r_scale ? (r_rl[PWR_W-1] ? -qs_l : qs_l) : r_rl;
    assign pick_r = r_scale ? (r_rr[PWR_W-1] ? -qs_r : qs_r) : r_rr;
    assign tcl_l  = f_clamp(WIDE_W'(pick_l), i_motor_max);
    assign tcl_r  = f_clamp(WIDE_W'(pick_r), i_motor_max);

    always_ff @(posedge i_clk) begin
        if (i_cmd.tgt_en) begin
            r_tl <= tcl_l[PWR_W-1:0];
            r_tr <= tcl_r[PWR_W-1:0];
        end
    end

    // slew limit toward target, then clamp to the limit
    assign cur_l  = WIDE_W'(r_app_l);
    assign cur_r  = WIDE_W'(r_app_r);
    assign dlt_l  = f_clamp(WIDE_W'(r_tl) - cur_l, i_max_step);
    assign dlt_r  = f_clamp(WIDE_W'(r_tr) - cur_r, i_max_step);
    assign new_l  = f_clamp(cur_l + dlt_l, i_motor_max);
    assign new_r  = f_clamp(cur_r + dlt_r, i_motor_max);
    assign nneg_l = -new_l[PWR_W-1:0];
    assign nneg_r = -new_r[PWR_W-1:0];

    // applied powers are state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_app_l <= '0;
            r_app_r <= '0;
        end else if (i_cmd.out_load) begin
            r_app_l <= new_l[PWR_W-1:0];
            r_app_r <= new_r[PWR_W-1:0];
        end
    end

    // result beat payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_tl <= r_tl;
            r_out_tr <= r_tr;
            r_rev_l  <= new_l[WIDE_W-1];
            r_rev_r  <= new_r[WIDE_W-1];
            r_duty_l <= new_l[WIDE_W-1] ? nneg_l[CFG_W-1:0] : new_l[CFG_W-1:0];
            r_duty_r <= new_r[WIDE_W-1] ? nneg_r[CFG_W-1:0] : new_r[CFG_W-1:0];
        end
    end

    assign o_target_left   = r_out_tl;
    assign o_target_right  = r_out_tr;
    assign o_left_power    = r_app_l;
    assign o_right_power   = r_app_r;
    assign o_left_reverse  = r_rev_l;
    assign o_right_reverse = r_rev_r;
    assign o_left_duty     = r_duty_l;
    assign o_right_duty    = r_duty_r;

    // checks
    `DDMS_ASSERT_NXT(a_mag_is_max, i_cmd.mix_en, (r_mag >= r_abs_l) && (r_mag >= r_abs_r))
    `DDMS_ASSERT_IMP(a_quot_in_range, i_cmd.tgt_en && r_scale, (q_l <= i_motor_max) && (q_r <= i_motor_max))
    `DDMS_ASSERT_NXT(a_duty_in_limit, i_cmd.out_load, (r_duty_l <= $past(i_motor_max)) && (r_duty_r <= $past(i_motor_max)))

endmodule
`default_nettype wire

/* hw/rtl/ddms_ctrl.sv */
`default_nettype none
`include "differential_drive_mixer_slew_core_macros.svh"
module ddms_ctrl import ddms_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_dp_cmd      o_cmd,
    input  wire t_dp_sts i_sts
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MIX  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_TGT  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       in_accept;
    logic       out_free;

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || i_out_ready;

    // sequencing
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_MIX;
                end
            end
            S_MIX: begin
                o_cmd.mix_en = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_en = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_TGT;
                end
            end
            S_TGT: begin
                o_cmd.tgt_en = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result beat valid
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // checks
    `DDMS_ASSERT_NXT(a_accept_starts, in_accept, r_state == S_MIX)
    `DDMS_ASSERT_IMP(a_load_when_free, o_cmd.out_load, !r_out_valid || i_out_ready)
    `DDMS_ASSERT_NXT(a_div_holds, (r_state == S_DIV) && !i_sts.div_last, r_state == S_DIV)

endmodule
`default_nettype wire

/* hw/rtl/differential_drive_mixer_slew_core.sv */
// differential drive mixer with acceleration limit
// command to result: load, mix, multiply, divide steps, target, output load
// one command in flight at a time; division uses a 10-step restoring divider
// a new command is taken while an earlier result beat still waits on the output
// synchronous active-low reset: motor_max 255, max_step 10, applied powers 0
`default_nettype none
module differential_drive_mixer_slew_core import ddms_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    ddms_cmd_if.sink                  i_cmd,
    ddms_res_if.source                o_res,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata
);

    logic [CFG_W-1:0] r_motor_max;
    logic [CFG_W-1:0] r_max_step;
    t_dp_cmd          dp_cmd;
    t_dp_sts          dp_sts;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_max <= MOTOR_MAX_RST;
            r_max_step  <= MAX_STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MOTOR_MAX: r_motor_max <= i_cfg_wdata;
                REG_MAX_STEP:  r_max_step  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // sequencer
    ddms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    // arithmetic
    ddms_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_sts           (dp_sts),
        .i_speed         (i_cmd.speed),
        .i_turn          (i_cmd.turn),
        .i_motor_max     (r_motor_max),
        .i_max_step      (r_max_step),
        .o_target_left   (o_res.target_left),
        .o_target_right  (o_res.target_right),
        .o_left_power    (o_res.left_power),
        .o_right_power   (o_res.right_power),
        .o_left_reverse  (o_res.left_reverse),
        .o_right_reverse (o_res.right_reverse),
        .o_left_duty     (o_res.left_duty),
        .o_right_duty    (o_res.right_duty)
    );

endmodule
`default_nettype wire
